// ===== rtl/ffps_pkg.sv =====
package ffps_pkg;

    localparam int PAGE_BYTES_DEF    = 16;
    localparam int ERASE_POLL_US_DEF = 1000000;
    localparam logic [31:0] DEVICE_ID_RST = 32'h012B_C043;
    localparam logic [7:0]  RETRY_RST     = 8'd10;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_DATA  = 3'd1;
    localparam logic [2:0] ACT_FIN   = 3'd2;
    localparam logic [2:0] ACT_REPLY = 3'd3;
    localparam logic [2:0] ACT_XFAIL = 3'd4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DELAY = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_ID  = 3'd1;
    localparam logic [2:0] ST_LINK    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_ERASE   = 3'd4;
    localparam logic [2:0] ST_PROG    = 3'd5;
    localparam logic [2:0] ST_REJECT  = 3'd6;

    localparam logic [0:0] CFG_DEVICE_ID = 1'd0;
    localparam logic [0:0] CFG_RETRY     = 1'd1;

    // frame codes issued by the front part
    localparam logic [3:0] FR_NONE    = 4'd0;
    localparam logic [3:0] FR_ID      = 4'd1;  // E0 00 00 00, read
    localparam logic [3:0] FR_STATUS  = 4'd2;  // 3C 00 00 00, read
    localparam logic [3:0] FR_ENABLE  = 4'd3;  // 74 08 00 00
    localparam logic [3:0] FR_ERASE   = 4'd4;  // 0E 04 00 00
    localparam logic [3:0] FR_DISABLE = 4'd5;  // 46 00 00 00
    localparam logic [3:0] FR_PDONE   = 4'd6;  // 5E 00 00 00
    localparam logic [3:0] FR_REFRESH = 4'd7;  // 79 00 00
    localparam logic [3:0] FR_EXIT    = 4'd8;  // 26 00 00
    localparam logic [3:0] FR_PAGE    = 4'd9;  // 70 00 00 01 + page

    typedef struct packed {
        logic [3:0]  frame1;
        logic [3:0]  frame2;
        logic        dly_en;
        logic [19:0] dly;
        logic        done_en;
        logic [2:0]  status;
    } cmd_t;

    function automatic logic [7:0] frame_byte(input logic [3:0] fr, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (fr)
            FR_ID:      b = (idx == 2'd0) ? 8'hE0 : 8'h00;
            FR_STATUS:  b = (idx == 2'd0) ? 8'h3C : 8'h00;
            FR_ENABLE:  b = (idx == 2'd0) ? 8'h74 : ((idx == 2'd1) ? 8'h08 : 8'h00);
            FR_ERASE:   b = (idx == 2'd0) ? 8'h0E : ((idx == 2'd1) ? 8'h04 : 8'h00);
            FR_DISABLE: b = (idx == 2'd0) ? 8'h46 : 8'h00;
            FR_PDONE:   b = (idx == 2'd0) ? 8'h5E : 8'h00;
            FR_REFRESH: b = (idx == 2'd0) ? 8'h79 : 8'h00;
            FR_EXIT:    b = (idx == 2'd0) ? 8'h26 : 8'h00;
            FR_PAGE:    b = (idx == 2'd0) ? 8'h70 : ((idx == 2'd3) ? 8'h01 : 8'h00);
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/ffps_ram.sv =====
module ffps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/ffps_front.sv =====
module ffps_front #(
    parameter int PAGE_BYTES    = ffps_pkg::PAGE_BYTES_DEF,
    parameter int ERASE_POLL_US = ffps_pkg::ERASE_POLL_US_DEF,
    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1,
    localparam int FW = $clog2(PAGE_BYTES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_action,
    input  logic [7:0]          s_data_byte,
    input  logic                s_end_of_chunk,
    input  logic [31:0]         s_reply_word,
    output logic                q_valid,
    input  logic                q_ready,
    output ffps_pkg::cmd_t      q_cmd,
    output logic [FW-1:0]       q_fill,
    output logic                ram_we,
    output logic [AW-1:0]       ram_waddr,
    output logic [7:0]          ram_wdata
);
    localparam logic [3:0] PH_IDLE = 4'd0, PH_READY = 4'd1, PH_AWAIT_ID = 4'd2,
        PH_WAIT_ENABLE = 4'd3, PH_WAIT_ERASE = 4'd4, PH_AWAIT_FAIL = 4'd5,
        PH_WAIT_PAGE = 4'd6, PH_WAIT_DONE = 4'd7, PH_AWAIT_DONEBIT = 4'd8,
        PH_WAIT_REFRESH = 4'd9;
    localparam int ERASE_US_R = (ERASE_POLL_US > 1000) ?
        (ERASE_POLL_US / 1000) * 1000 : ERASE_POLL_US;
    localparam logic [FW-1:0] FULL = FW'(PAGE_BYTES);

    logic [31:0]   dev_id_reg;
    logic [7:0]    retry_reg;
    logic [3:0]    phase_reg, phase_next;
    logic [7:0]    poll_reg, poll_next, poll_inc;
    logic [FW-1:0] fill_reg, fill_next, fill_inc;
    logic          chunk_reg, chunk_next;
    logic          clean_reg, clean_next;
    logic          pending, take;
    ffps_pkg::cmd_t cmd;

    assign s_ready = q_ready;
    assign take    = s_valid && q_ready;
    assign pending = (phase_reg != PH_IDLE) && (phase_reg != PH_READY);
    assign poll_inc = (poll_reg == 8'hFF) ? poll_reg : poll_reg + 8'd1;
    assign fill_inc = (fill_reg < FULL) ? fill_reg + FW'(1) : fill_reg;

    function automatic logic [19:0] poll_us(input logic [3:0] ph);
        logic [19:0] us;
        unique case (ph)
            PH_WAIT_ENABLE:  us = 20'd2;
            PH_WAIT_ERASE:   us = 20'(ERASE_US_R);
            PH_WAIT_REFRESH: us = 20'd1000;
            default:         us = 20'd50;
        endcase
        return us;
    endfunction

    always_comb begin
        phase_next = phase_reg;
        poll_next  = poll_reg;
        fill_next  = fill_reg;
        chunk_next = chunk_reg;
        clean_next = clean_reg;
        cmd        = '0;
        ram_we     = 1'b0;
        ram_waddr  = fill_reg[AW-1:0];
        ram_wdata  = s_data_byte;
        q_fill     = fill_reg;
        if (s_action == ffps_pkg::ACT_START && !pending) begin
            fill_next = '0; chunk_next = 1'b0; clean_next = 1'b0;
            cmd.frame1 = ffps_pkg::FR_ID;
            phase_next = PH_AWAIT_ID;
        end else if (s_action == ffps_pkg::ACT_DATA && phase_reg == PH_READY) begin
            ram_we = take && (fill_reg < FULL);
            if (s_end_of_chunk) chunk_next = 1'b1;
            fill_next = fill_inc;
            if (fill_inc >= FULL || s_end_of_chunk) begin
                q_fill = fill_inc;
                cmd.frame1 = ffps_pkg::FR_PAGE;
                cmd.frame2 = ffps_pkg::FR_STATUS;
                fill_next = '0; poll_next = '0; phase_next = PH_WAIT_PAGE;
            end
        end else if (s_action == ffps_pkg::ACT_FIN && phase_reg == PH_READY) begin
            fill_next = '0; chunk_next = 1'b0;
            cmd.frame1 = ffps_pkg::FR_PDONE;
            cmd.frame2 = ffps_pkg::FR_STATUS;
            poll_next = '0; phase_next = PH_WAIT_DONE;
        end else if ((s_action == ffps_pkg::ACT_REPLY || s_action == ffps_pkg::ACT_XFAIL)
                     && pending) begin
            logic fail;
            logic [2:0] code;
            fail = 1'b0;
            code = ffps_pkg::ST_LINK;
            if (s_action == ffps_pkg::ACT_XFAIL) begin
                fail = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_AWAIT_ID: begin
                        if (s_reply_word != dev_id_reg) begin
                            fail = 1'b1; code = ffps_pkg::ST_BAD_ID;
                        end else begin
                            cmd.frame1 = ffps_pkg::FR_ENABLE;
                            cmd.frame2 = ffps_pkg::FR_STATUS;
                            poll_next = '0; phase_next = PH_WAIT_ENABLE;
                        end
                    end
                    PH_AWAIT_FAIL: begin
                        if (s_reply_word[13]) begin
                            fail = 1'b1; code = ffps_pkg::ST_ERASE;
                        end else begin
                            cmd.frame1 = ffps_pkg::FR_DISABLE;
                            cmd.done_en = 1'b1;
                            phase_next = PH_READY;
                            fill_next = '0; chunk_next = 1'b0;
                        end
                    end
                    PH_AWAIT_DONEBIT: begin
                        if (!s_reply_word[8]) begin
                            clean_next = 1'b1;
                            cmd.frame1 = ffps_pkg::FR_ERASE;
                            cmd.frame2 = ffps_pkg::FR_STATUS;
                            poll_next = '0; phase_next = PH_WAIT_ERASE;
                        end else begin
                            cmd.frame1 = ffps_pkg::FR_EXIT;
                            cmd.done_en = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        poll_next = poll_inc;
                        if (poll_inc >= retry_reg) begin
                            fail = 1'b1; code = ffps_pkg::ST_TIMEOUT;
                        end else begin
                            cmd.dly_en = 1'b1;
                            cmd.dly = poll_us(phase_reg);
                            if (s_reply_word[12]) begin
                                cmd.frame2 = ffps_pkg::FR_STATUS;
                            end else begin
                                unique case (phase_reg)
                                    PH_WAIT_ENABLE: begin
                                        cmd.frame1 = ffps_pkg::FR_ERASE;
                                        cmd.frame2 = ffps_pkg::FR_STATUS;
                                        poll_next = '0; phase_next = PH_WAIT_ERASE;
                                    end
                                    PH_WAIT_ERASE: begin
                                        if (clean_reg) begin
                                            cmd.frame1 = ffps_pkg::FR_REFRESH;
                                            cmd.frame2 = ffps_pkg::FR_STATUS;
                                            poll_next = '0;
                                            phase_next = PH_WAIT_REFRESH;
                                        end else begin
                                            cmd.frame2 = ffps_pkg::FR_STATUS;
                                            phase_next = PH_AWAIT_FAIL;
                                        end
                                    end
                                    PH_WAIT_PAGE: begin
                                        phase_next = PH_READY;
                                        if (chunk_reg) begin
                                            chunk_next = 1'b0;
                                            cmd.done_en = 1'b1;
                                        end
                                    end
                                    PH_WAIT_DONE: begin
                                        cmd.frame2 = ffps_pkg::FR_STATUS;
                                        phase_next = PH_AWAIT_DONEBIT;
                                    end
                                    default: begin
                                        fail = 1'b1; code = ffps_pkg::ST_PROG;
                                    end
                                endcase
                            end
                        end
                    end
                endcase
            end
            if (fail) begin
                cmd.done_en = 1'b1;
                cmd.status = clean_reg ? ffps_pkg::ST_PROG : code;
                clean_next = 1'b0; phase_next = PH_IDLE;
                fill_next = '0; chunk_next = 1'b0; poll_next = '0;
            end
        end else begin
            cmd.done_en = 1'b1;
            cmd.status = ffps_pkg::ST_REJECT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_id_reg <= ffps_pkg::DEVICE_ID_RST;
            retry_reg  <= ffps_pkg::RETRY_RST;
            phase_reg  <= PH_IDLE;
            poll_reg   <= '0;
            fill_reg   <= '0;
            chunk_reg  <= 1'b0;
            clean_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ffps_pkg::CFG_DEVICE_ID: dev_id_reg <= cfg_data;
                    default:                 retry_reg  <= cfg_data[7:0];
                endcase
            end
            if (take) begin
                phase_reg <= phase_next;
                poll_reg  <= poll_next;
                fill_reg  <= fill_next;
                chunk_reg <= chunk_next;
                clean_reg <= clean_next;
            end
        end
    end

    assign q_valid = take;
    assign q_cmd   = cmd;
endmodule

// ===== rtl/ffps_back.sv =====
module ffps_back #(
    parameter int PAGE_BYTES = ffps_pkg::PAGE_BYTES_DEF,
    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1,
    localparam int FW = $clog2(PAGE_BYTES + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  ffps_pkg::cmd_t q_cmd,
    input  logic [FW-1:0]  q_fill,
    output logic [AW-1:0]  ram_raddr,
    input  logic [7:0]     ram_rdata,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_kind,
    output logic [7:0]     m_serial_byte,
    output logic           m_frame_end,
    output logic           m_read_follows,
    output logic [19:0]    m_wait_us,
    output logic [2:0]     m_op_status,
    output logic           m_last
);
    localparam logic [2:0] S_IDLE = 3'd0, S_F1 = 3'd1, S_PAGE = 3'd2, S_DLY = 3'd3,
        S_F2 = 3'd4, S_DONE = 3'd5;
    localparam int CW = $clog2(PAGE_BYTES + 1);

    ffps_pkg::cmd_t cmd_reg;
    logic [FW-1:0]  fill_reg;
    logic [2:0]     st_reg, st_after;
    logic [1:0]     idx_reg;
    logic [CW-1:0]  pg_reg;
    logic [CW-1:0]  rd_ptr;
    logic           pend_reg;     // page byte requested from RAM, data valid now
    logic           ov_reg;
    logic [1:0]     o_kind;
    logic [7:0]     o_byte;
    logic           o_fe, o_rf, o_last;
    logic [19:0]    o_dly;
    logic [2:0]     o_st;
    logic           emit, out_free;

    assign out_free = !ov_reg || m_ready;
    assign q_ready  = (st_reg == S_IDLE);
    assign m_valid  = ov_reg;
    // keep the address on the shown byte while the output stalls
    assign rd_ptr    = pend_reg ? pg_reg - CW'(1) : pg_reg;
    assign ram_raddr = rd_ptr[AW-1:0];

    // next state after the current step, for deciding "last"
    function automatic logic [2:0] after_f1(input ffps_pkg::cmd_t c);
        if (c.frame2 != ffps_pkg::FR_NONE) return S_F2;
        if (c.done_en)                     return S_DONE;
        return S_IDLE;
    endfunction

    function automatic logic [2:0] after_dly(input ffps_pkg::cmd_t c);
        if (c.frame1 != ffps_pkg::FR_NONE) return S_F1;
        return after_f1(c);
    endfunction

    // a poll delay always goes ahead of the frames it triggers
    function automatic logic [2:0] first_state(input ffps_pkg::cmd_t c);
        if (c.dly_en) return S_DLY;
        return after_dly(c);
    endfunction

    always_comb begin
        emit = 1'b0; st_after = st_reg;
        o_kind = ffps_pkg::KIND_BYTE; o_byte = '0; o_fe = 1'b0; o_rf = 1'b0;
        o_dly = '0; o_st = '0;
        unique case (st_reg)
            S_F1: begin
                emit = out_free;
                o_byte = ffps_pkg::frame_byte(cmd_reg.frame1, idx_reg);
                if (cmd_reg.frame1 == ffps_pkg::FR_PAGE) begin
                    st_after = (idx_reg == 2'd3) ? S_PAGE : S_F1;
                end else if (idx_reg == 2'd3 || (idx_reg == 2'd2 &&
                             (cmd_reg.frame1 == ffps_pkg::FR_REFRESH ||
                              cmd_reg.frame1 == ffps_pkg::FR_EXIT))) begin
                    o_fe = 1'b1;
                    o_rf = (cmd_reg.frame1 == ffps_pkg::FR_ID);
                    st_after = after_f1(cmd_reg);
                end
            end
            S_PAGE: begin
                emit = out_free && pend_reg;
                o_byte = (pg_reg <= CW'(fill_reg)) ? ram_rdata : 8'hFF;
                if (pg_reg == CW'(PAGE_BYTES)) begin
                    o_fe = 1'b1;
                    st_after = after_f1(cmd_reg);
                end
            end
            S_DLY: begin
                emit = out_free;
                o_kind = ffps_pkg::KIND_DELAY; o_dly = cmd_reg.dly;
                st_after = after_dly(cmd_reg);
            end
            S_F2: begin
                emit = out_free;
                o_byte = ffps_pkg::frame_byte(cmd_reg.frame2, idx_reg);
                if (idx_reg == 2'd3) begin
                    o_fe = 1'b1; o_rf = 1'b1;
                    st_after = cmd_reg.done_en ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                emit = out_free;
                o_kind = ffps_pkg::KIND_DONE; o_st = cmd_reg.status;
                st_after = S_IDLE;
            end
            default: ;
        endcase
        o_last = (st_after == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; ov_reg <= 1'b0; idx_reg <= '0; pg_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (m_ready) ov_reg <= 1'b0;
            if (q_valid && q_ready) begin
                cmd_reg  <= q_cmd;
                fill_reg <= q_fill;
                st_reg   <= first_state(q_cmd);
                idx_reg  <= '0;
            end else if (emit) begin
                ov_reg <= 1'b1;
                m_kind <= o_kind; m_serial_byte <= o_byte; m_frame_end <= o_fe;
                m_read_follows <= o_rf; m_wait_us <= o_dly; m_op_status <= o_st;
                m_last <= o_last;
                idx_reg <= (st_after != st_reg) ? 2'd0 : idx_reg + 2'd1;
                if (st_reg == S_F1 && st_after == S_PAGE) begin
                    pg_reg <= '0; pend_reg <= 1'b0;
                end
                if (st_reg == S_PAGE) pend_reg <= 1'b0;
                st_reg <= (st_after == S_PAGE && st_reg == S_PAGE) ? S_PAGE :
                          ((st_reg == S_PAGE && pg_reg == CW'(PAGE_BYTES)) ||
                           st_reg != S_PAGE) ? st_after : S_PAGE;
            end else if (st_reg == S_PAGE && !pend_reg) begin
                // ram read for byte pg_reg; pg_reg counts 1..PAGE_BYTES when shown
                pend_reg <= 1'b1;
                pg_reg   <= pg_reg + CW'(1);
            end
        end
    end
endmodule

// ===== rtl/fpga_flash_program_sequencer_top.sv =====
// channel  | ports                                          | transfer when
// input    | s_action s_data_byte s_end_of_chunk s_reply_word | s_valid && s_ready
// result   | m_kind .. m_last                               | m_valid && m_ready
// An item is classified combinationally as it transfers and is written to the
// queue register; the back part then emits one result per cycle while m_ready is
// high, page bytes slower, as each one is first read from the page RAM.
// s_ready is low while the queue slot holds an item the back part has not
// taken yet. A stalled m_ready holds the output register.
// aresetn is synchronous; the page RAM is not cleared.
module fpga_flash_program_sequencer_top #(
    parameter int PAGE_BYTES    = ffps_pkg::PAGE_BYTES_DEF,
    parameter int ERASE_POLL_US = ffps_pkg::ERASE_POLL_US_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_chunk,
    input  logic [31:0] s_reply_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_serial_byte,
    output logic        m_frame_end,
    output logic        m_read_follows,
    output logic [19:0] m_wait_us,
    output logic [2:0]  m_op_status,
    output logic        m_last
);
    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int FW = $clog2(PAGE_BYTES + 1);

    logic           q_valid, q_ready, ram_we;
    ffps_pkg::cmd_t q_cmd, q_cmd_reg;
    logic [FW-1:0]  q_fill, q_fill_reg;
    logic           qv_reg, bq_ready;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata;

    // one-entry queue between front and back
    assign q_ready = !qv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg <= 1'b0;
        end else if (q_valid) begin
            qv_reg <= 1'b1;
        end else if (bq_ready) begin
            qv_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (q_valid) begin
            q_cmd_reg  <= q_cmd;
            q_fill_reg <= q_fill;
        end
    end

    ffps_front #(.PAGE_BYTES(PAGE_BYTES), .ERASE_POLL_US(ERASE_POLL_US)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_action, .s_data_byte, .s_end_of_chunk, .s_reply_word,
        .q_valid, .q_ready, .q_cmd, .q_fill, .ram_we, .ram_waddr, .ram_wdata
    );

    ffps_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
        .aclk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    ffps_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
        .aclk, .aresetn, .q_valid(qv_reg), .q_ready(bq_ready), .q_cmd(q_cmd_reg),
        .q_fill(q_fill_reg), .ram_raddr, .ram_rdata, .m_valid, .m_ready, .m_kind,
        .m_serial_byte, .m_frame_end, .m_read_follows, .m_wait_us, .m_op_status, .m_last
    );
endmodule

// ===== rtl/ffps_checker.sv =====
module ffps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_serial_byte,
    input logic        m_frame_end,
    input logic        m_read_follows,
    input logic [19:0] m_wait_us,
    input logic [2:0]  m_op_status
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_serial_byte))
        else $error("result changed while stalled");
    a_rf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_follows |-> m_frame_end)
        else $error("read_follows off frame end");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind != 2'd3)
        else $error("bad kind");
    a_dly: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == ffps_pkg::KIND_DELAY |-> m_wait_us != 20'd0)
        else $error("zero delay");
    a_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != ffps_pkg::KIND_DONE |-> m_op_status == 3'd0)
        else $error("status on non-complete result");
endmodule

bind fpga_flash_program_sequencer_top ffps_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_kind, .m_serial_byte,
    .m_frame_end, .m_read_follows, .m_wait_us, .m_op_status
);
